// ----- sv/blfc_pkg.sv -----
// ----------------------------------------------------------------------------
// blfc_pkg
// Shared types and constants of the bank latch with flash command decoding.
// ----------------------------------------------------------------------------
package blfc_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int PRG_W      = 5;
   localparam int CHR_W      = 2;
   localparam int MIR_W      = 3;
   localparam int FOP_W      = 2;
   localparam int OFFSET_W   = 14;
   localparam int COUNT_W    = 6;
   localparam int SUBMAP_W   = 3;
   localparam int NTMODE_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam int DEF_MAX_PRG_BANKS = 32;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_FLASHABLE  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SUBMAPPER  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_NT_MODE    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BANK_COUNT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CHR_MASK   = 3'd4;

   localparam logic [COUNT_W-1:0] BANK_COUNT_RESET = 6'd32;
   localparam logic [CHR_W-1:0]   CHR_MASK_RESET   = 2'd3;

   // Submapper codes.
   localparam logic [SUBMAP_W-1:0] SUBMAP_CONFLICT   = 3'd0;
   localparam logic [SUBMAP_W-1:0] SUBMAP_HI_ONLY    = 3'd1;
   localparam logic [SUBMAP_W-1:0] SUBMAP_CONFLICT_B = 3'd2;
   localparam logic [SUBMAP_W-1:0] SUBMAP_HV_D7      = 3'd3;
   localparam logic [SUBMAP_W-1:0] SUBMAP_HI_ONLY_B  = 3'd4;

   // Nametable modes.
   localparam logic [NTMODE_W-1:0] NT_HORZ   = 2'd0;
   localparam logic [NTMODE_W-1:0] NT_VERT   = 2'd1;
   localparam logic [NTMODE_W-1:0] NT_SINGLE = 2'd2;
   localparam logic [NTMODE_W-1:0] NT_FOUR   = 2'd3;

   // Addresses and data bytes of the flash command protocol.
   localparam logic [ADDR_W-1:0] ADDR_HI_BASE  = 16'hC000;
   localparam logic [ADDR_W-1:0] ADDR_UNLOCK_A = 16'h9555;
   localparam logic [ADDR_W-1:0] ADDR_UNLOCK_B = 16'hAAAA;
   localparam logic [ADDR_W-1:0] ERASE_MASK    = 16'h3000;

   localparam logic [DATA_W-1:0] DAT_ONE     = 8'h01;
   localparam logic [DATA_W-1:0] DAT_ZERO    = 8'h00;
   localparam logic [DATA_W-1:0] DAT_AA      = 8'hAA;
   localparam logic [DATA_W-1:0] DAT_55      = 8'h55;
   localparam logic [DATA_W-1:0] DAT_ID      = 8'h90;
   localparam logic [DATA_W-1:0] DAT_PROGRAM = 8'hA0;
   localparam logic [DATA_W-1:0] DAT_ERASE   = 8'h80;
   localparam logic [DATA_W-1:0] DAT_CONFIRM = 8'h30;
   localparam logic [DATA_W-1:0] DAT_RESET   = 8'hF0;
   localparam logic [DATA_W-1:0] DAT_ERASED  = 8'hFF;

   typedef enum logic [FOP_W-1:0] {
      FOP_NONE    = 2'd0,
      FOP_PROGRAM = 2'd1,
      FOP_ERASE   = 2'd2
   } fop_type;

   typedef enum logic [MIR_W-1:0] {
      MIR_HORZ     = 3'd0,
      MIR_VERT     = 3'd1,
      MIR_SCREEN_A = 3'd2,
      MIR_SCREEN_B = 3'd3,
      MIR_FOUR     = 3'd4
   } mir_type;

   typedef enum logic [3:0] {
      FL_IDLE     = 4'd0,
      FL_C1       = 4'd1,
      FL_AA       = 4'd2,
      FL_C0       = 4'd3,
      FL_55       = 4'd4,
      FL_C1B      = 4'd5,
      FL_WR_BANK  = 4'd6,
      FL_WR_DATA  = 4'd7,
      FL_ER_C1    = 4'd8,
      FL_ER_AA    = 4'd9,
      FL_ER_C0    = 4'd10,
      FL_ER_55    = 4'd11,
      FL_ER_BANK  = 4'd12,
      FL_ER_DATA  = 4'd13
   } flash_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE    = 2'd0,
      SEQ_MOD_PRG = 2'd1,
      SEQ_MOD_TGT = 2'd2,
      SEQ_PUSH    = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic             done;
      logic [PRG_W-1:0] rem;
   } mod_res_type;

   typedef struct packed {
      fop_type             op;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   data;
   } flash_res_type;

endpackage

// ----- sv/blfc_ifs.sv -----
// ----------------------------------------------------------------------------
// blfc_ifs
// Handshake channels for CPU write items and mapping result items.
// ----------------------------------------------------------------------------
interface blfc_req_if;
   logic                        valid;
   logic                        ready;
   logic [blfc_pkg::ADDR_W-1:0] addr;
   logic [blfc_pkg::DATA_W-1:0] data;
   logic [blfc_pkg::DATA_W-1:0] rom_value;

   modport source (output valid, addr, data, rom_value, input ready);
   modport sink   (input valid, addr, data, rom_value, output ready);
endinterface

interface blfc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          latch_written;
   logic [blfc_pkg::PRG_W-1:0]    prg_bank;
   logic [blfc_pkg::CHR_W-1:0]    chr_bank;
   logic [blfc_pkg::MIR_W-1:0]    mirroring;
   logic                          id_mode;
   logic [blfc_pkg::FOP_W-1:0]    flash_op;
   logic [blfc_pkg::PRG_W-1:0]    flash_bank;
   logic [blfc_pkg::OFFSET_W-1:0] flash_offset;
   logic [blfc_pkg::DATA_W-1:0]   flash_data;

   modport source (output valid, latch_written, prg_bank, chr_bank, mirroring, id_mode,
                   flash_op, flash_bank, flash_offset, flash_data, input ready);
   modport sink   (input valid, latch_written, prg_bank, chr_bank, mirroring, id_mode,
                   flash_op, flash_bank, flash_offset, flash_data, output ready);
endinterface

// ----- sv/blfc_mod_unit.sv -----
// ----------------------------------------------------------------------------
// blfc_mod_unit
// Shared restoring remainder unit: bank number modulo the PRG bank count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module blfc_mod_unit #(
   parameter int MAX_PRG_BANKS = blfc_pkg::DEF_MAX_PRG_BANKS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [blfc_pkg::PRG_W-1:0]   dividend,
   input  logic [blfc_pkg::COUNT_W-1:0] bank_count,
   output blfc_pkg::mod_res_type        result
);
   import blfc_pkg::*;

   localparam int BANK_W = (MAX_PRG_BANKS > 1) ? $clog2(MAX_PRG_BANKS) : 1;
   localparam int CNT_W  = $clog2(PRG_W + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PRG_BANKS);

   logic [COUNT_W-1:0] divisor;
   logic [COUNT_W-1:0] trial;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [PRG_W-1:0]   shift_ff, shift_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // A count of zero acts as one bank; counts above MAX_PRG_BANKS saturate.
   always_comb begin
      priority if (bank_count == '0) begin
         divisor = COUNT_W'(1);
      end else if (bank_count > MAX_COUNT) begin
         divisor = MAX_COUNT;
      end else begin
         divisor = bank_count;
      end
   end

   // The partial remainder stays below the divisor, so its low bits hold it.
   assign trial = {rem_ff[COUNT_W-2:0], shift_ff[PRG_W-1]};

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         shift_in = dividend;
         cnt_in   = CNT_W'(PRG_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = (trial >= divisor) ? trial - divisor : trial;
         shift_in = {shift_ff[PRG_W-2:0], 1'b0};
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign result.done = done_ff;
   assign result.rem  = PRG_W'(rem_ff[BANK_W-1:0]);

endmodule

// ----- sv/blfc_flash_dec.sv -----
// ----------------------------------------------------------------------------
// blfc_flash_dec
// Flash command decoder: unlock sequence, ID mode, byte program, sector
// erase and the reset command.
// ----------------------------------------------------------------------------
module blfc_flash_dec (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        write_en,
   input  logic [blfc_pkg::ADDR_W-1:0] addr,
   input  logic [blfc_pkg::DATA_W-1:0] data,
   output blfc_pkg::flash_res_type     flash_res,
   output logic                        id_active,
   output logic [blfc_pkg::PRG_W-1:0]  target
);
   import blfc_pkg::*;

   flash_state_type  state_ff, state_in;
   logic             id_ff, id_in;
   logic [PRG_W-1:0] target_ff, target_in;
   logic             hi;
   logic             is_reset;

   assign hi       = addr >= ADDR_HI_BASE;
   assign is_reset = data == DAT_RESET;

   // Next state, ID flag and target bank.
   always_comb begin
      state_in  = state_ff;
      id_in     = id_ff;
      target_in = target_ff;
      if (write_en) begin
         state_in = FL_IDLE;
         if (is_reset) begin
            id_in = 1'b0;
         end else begin
            case (state_ff)
               FL_IDLE: begin
                  if (addr == ADDR_HI_BASE && data == DAT_ONE) state_in = FL_C1;
               end
               FL_C1: begin
                  if (addr == ADDR_UNLOCK_A && data == DAT_AA) state_in = FL_AA;
               end
               FL_AA: begin
                  if (addr == ADDR_HI_BASE && data == DAT_ZERO) state_in = FL_C0;
               end
               FL_C0: begin
                  if (addr == ADDR_UNLOCK_B && data == DAT_55) state_in = FL_55;
               end
               FL_55: begin
                  if (addr == ADDR_HI_BASE && data == DAT_ONE) state_in = FL_C1B;
               end
               FL_C1B: begin
                  if (addr == ADDR_UNLOCK_A) begin
                     if (data == DAT_ID) id_in = 1'b1;
                     else if (data == DAT_PROGRAM) state_in = FL_WR_BANK;
                     else if (data == DAT_ERASE) state_in = FL_ER_C1;
                  end
               end
               FL_WR_BANK: begin
                  if (hi) begin
                     target_in = data[PRG_W-1:0];
                     state_in  = FL_WR_DATA;
                  end
               end
               FL_ER_C1: begin
                  if (addr == ADDR_HI_BASE && data == DAT_ONE) state_in = FL_ER_AA;
               end
               FL_ER_AA: begin
                  if (addr == ADDR_UNLOCK_A && data == DAT_AA) state_in = FL_ER_C0;
               end
               FL_ER_C0: begin
                  if (addr == ADDR_HI_BASE && data == DAT_ZERO) state_in = FL_ER_55;
               end
               FL_ER_55: begin
                  if (addr == ADDR_UNLOCK_B && data == DAT_55) state_in = FL_ER_BANK;
               end
               FL_ER_BANK: begin
                  if (hi) begin
                     target_in = data[PRG_W-1:0];
                     state_in  = FL_ER_DATA;
                  end
               end
               default: begin
                  state_in = FL_IDLE;
               end
            endcase
         end
      end
   end

   // Operation completed by the current write.
   always_comb begin
      flash_res.op     = FOP_NONE;
      flash_res.offset = '0;
      flash_res.data   = '0;
      if (!is_reset && !hi) begin
         if (state_ff == FL_WR_DATA) begin
            flash_res.op     = FOP_PROGRAM;
            flash_res.offset = addr[OFFSET_W-1:0];
            flash_res.data   = data;
         end else if (state_ff == FL_ER_DATA && data == DAT_CONFIRM) begin
            flash_res.op     = FOP_ERASE;
            flash_res.offset = addr[OFFSET_W-1:0] & ERASE_MASK[OFFSET_W-1:0];
            flash_res.data   = DAT_ERASED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FL_IDLE;
         id_ff     <= 1'b0;
         target_ff <= '0;
      end else begin
         state_ff  <= state_in;
         id_ff     <= id_in;
         target_ff <= target_in;
      end
   end

   assign id_active = id_ff;
   assign target    = target_ff;

endmodule

// ----- sv/bank_latch_with_flash_commands.sv -----
// ----------------------------------------------------------------------------
// bank_latch_with_flash_commands
// Discrete-logic style PRG/CHR bank latch with flash command decoding.
// ----------------------------------------------------------------------------
// Each item on req_ch is one CPU write to cartridge space together with the
// ROM byte mapped at that address. For every item the block returns one item
// on rsp_ch: whether the latch was loaded, the PRG and CHR banks, mirroring,
// the ID mode flag and any flash program or erase that this write completes.
// The configuration registers sit on the csr_ APB port; the user must write
// them only while no item is in flight, which the block does not enforce.
// An accepted item has its PRG bank reduced, then its flash target bank when
// it completes a flash operation, and its result then moves into the output
// register. The PRG bank and the flash target bank are each reduced modulo
// the bank count by one shared remainder unit; one reduction is a load and
// five one-bit steps. The block takes the next item only once the result
// has moved into the output register, so it holds one item in work at most.
// A result waits in the output register while rsp_ch.ready is low; the
// block still accepts and works on one further item meanwhile, then holds.
// Synchronous reset clears the bank latch, the flash decoder and the
// registers to their defaults, with no result pending.
// ----------------------------------------------------------------------------
module bank_latch_with_flash_commands #(
   parameter int MAX_PRG_BANKS = blfc_pkg::DEF_MAX_PRG_BANKS
) (
   input  logic                            clock,
   input  logic                            reset,
   blfc_req_if.sink                        req_ch,
   blfc_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [blfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [blfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [blfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import blfc_pkg::*;

   // Configuration registers.
   logic                flashable_ff;
   logic [SUBMAP_W-1:0] submapper_ff;
   logic [NTMODE_W-1:0] nt_mode_ff;
   logic [COUNT_W-1:0]  bank_count_ff;
   logic [CHR_W-1:0]    chr_mask_ff;
   logic                csr_write;
   logic [REG_IDX_W-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         flashable_ff  <= 1'b0;
         submapper_ff  <= '0;
         nt_mode_ff    <= NT_HORZ;
         bank_count_ff <= BANK_COUNT_RESET;
         chr_mask_ff   <= CHR_MASK_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            REG_FLASHABLE:  flashable_ff  <= csr_pwdata[0];
            REG_SUBMAPPER:  submapper_ff  <= csr_pwdata[SUBMAP_W-1:0];
            REG_NT_MODE:    nt_mode_ff    <= csr_pwdata[NTMODE_W-1:0];
            REG_BANK_COUNT: bank_count_ff <= csr_pwdata[COUNT_W-1:0];
            REG_CHR_MASK:   chr_mask_ff   <= csr_pwdata[CHR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FLASHABLE:  csr_prdata = CSR_DATA_W'(flashable_ff);
         REG_SUBMAPPER:  csr_prdata = CSR_DATA_W'(submapper_ff);
         REG_NT_MODE:    csr_prdata = CSR_DATA_W'(nt_mode_ff);
         REG_BANK_COUNT: csr_prdata = CSR_DATA_W'(bank_count_ff);
         REG_CHR_MASK:   csr_prdata = CSR_DATA_W'(chr_mask_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Sequencer and item state.
   seq_state_type       state_ff, state_in;
   logic [DATA_W-1:0]   latch_ff, latch_in;
   logic                written_ff, written_in;
   fop_type             op_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [DATA_W-1:0]   fdata_ff;
   logic [PRG_W-1:0]    prg_ff;
   logic [PRG_W-1:0]    fbank_ff;

   logic                accept;
   logic                hi;
   logic                gated;
   logic                conflict;
   logic                mod_start;
   logic [PRG_W-1:0]    mod_dividend;
   logic                cap_prg;
   logic                cap_fbank;
   logic                push;
   mod_res_type         mod_res;
   flash_res_type       flash_res;
   logic                id_active;
   logic [PRG_W-1:0]    target;
   mir_type             mirror;

   assign accept = req_ch.valid && req_ch.ready;
   assign hi     = req_ch.addr >= ADDR_HI_BASE;

   assign gated    = (submapper_ff == SUBMAP_HI_ONLY || submapper_ff == SUBMAP_HV_D7 ||
                      submapper_ff == SUBMAP_HI_ONLY_B) && !hi;
   assign conflict = submapper_ff == SUBMAP_CONFLICT || submapper_ff == SUBMAP_CONFLICT_B;

   // Latch update for the write being accepted.
   always_comb begin
      latch_in   = latch_ff;
      written_in = 1'b0;
      if (flashable_ff) begin
         if (hi) begin
            latch_in   = req_ch.data;
            written_in = 1'b1;
         end
      end else if (!gated) begin
         latch_in   = conflict ? (req_ch.data & req_ch.rom_value) : req_ch.data;
         written_in = 1'b1;
      end
   end

   blfc_flash_dec u_flash_dec (
      .clock     (clock),
      .reset     (reset),
      .write_en  (accept && flashable_ff),
      .addr      (req_ch.addr),
      .data      (req_ch.data),
      .flash_res (flash_res),
      .id_active (id_active),
      .target    (target)
   );

   blfc_mod_unit #(
      .MAX_PRG_BANKS (MAX_PRG_BANKS)
   ) u_mod_unit (
      .clock      (clock),
      .reset      (reset),
      .start      (mod_start),
      .dividend   (mod_dividend),
      .bank_count (bank_count_ff),
      .result     (mod_res)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) state_in = SEQ_MOD_PRG;
         end
         SEQ_MOD_PRG: begin
            if (mod_res.done) state_in = (op_ff != FOP_NONE) ? SEQ_MOD_TGT : SEQ_PUSH;
         end
         SEQ_MOD_TGT: begin
            if (mod_res.done) state_in = SEQ_PUSH;
         end
         SEQ_PUSH: begin
            if (!rsp_ch.valid || rsp_ch.ready) state_in = SEQ_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ch.ready = 1'b0;
      mod_start    = 1'b0;
      mod_dividend = latch_in[PRG_W-1:0];
      cap_prg      = 1'b0;
      cap_fbank    = 1'b0;
      push         = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_ch.ready = 1'b1;
            mod_start    = accept;
         end
         SEQ_MOD_PRG: begin
            cap_prg      = mod_res.done;
            mod_start    = mod_res.done && op_ff != FOP_NONE;
            mod_dividend = target;
         end
         SEQ_MOD_TGT: begin
            cap_fbank = mod_res.done;
         end
         SEQ_PUSH: begin
            push = !rsp_ch.valid || rsp_ch.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         latch_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) latch_ff <= latch_in;
      end
      if (accept) begin
         written_ff <= written_in;
         op_ff      <= flashable_ff ? flash_res.op : FOP_NONE;
         offset_ff  <= flashable_ff ? flash_res.offset : '0;
         fdata_ff   <= flashable_ff ? flash_res.data : '0;
         fbank_ff   <= '0;
      end
      if (cap_prg) prg_ff <= mod_res.rem;
      if (cap_fbank) fbank_ff <= mod_res.rem;
   end

   always_comb begin
      if (submapper_ff == SUBMAP_HV_D7) begin
         mirror = latch_ff[DATA_W-1] ? MIR_VERT : MIR_HORZ;
      end else begin
         unique case (nt_mode_ff)
            NT_HORZ:   mirror = MIR_HORZ;
            NT_VERT:   mirror = MIR_VERT;
            NT_SINGLE: mirror = latch_ff[DATA_W-1] ? MIR_SCREEN_A : MIR_SCREEN_B;
            NT_FOUR:   mirror = MIR_FOUR;
         endcase
      end
   end

   // Output register.
   logic                rsp_valid_ff;
   logic                rsp_written_ff;
   logic [PRG_W-1:0]    rsp_prg_ff;
   logic [CHR_W-1:0]    rsp_chr_ff;
   mir_type             rsp_mir_ff;
   logic                rsp_id_ff;
   fop_type             rsp_op_ff;
   logic [PRG_W-1:0]    rsp_fbank_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [DATA_W-1:0]   rsp_fdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push) begin
         rsp_written_ff <= written_ff;
         rsp_prg_ff     <= prg_ff;
         rsp_chr_ff     <= latch_ff[6:5] & chr_mask_ff;
         rsp_mir_ff     <= mirror;
         rsp_id_ff      <= id_active;
         rsp_op_ff      <= op_ff;
         rsp_fbank_ff   <= fbank_ff;
         rsp_offset_ff  <= offset_ff;
         rsp_fdata_ff   <= fdata_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.latch_written = rsp_written_ff;
   assign rsp_ch.prg_bank      = rsp_prg_ff;
   assign rsp_ch.chr_bank      = rsp_chr_ff;
   assign rsp_ch.mirroring     = rsp_mir_ff;
   assign rsp_ch.id_mode       = rsp_id_ff;
   assign rsp_ch.flash_op      = rsp_op_ff;
   assign rsp_ch.flash_bank    = rsp_fbank_ff;
   assign rsp_ch.flash_offset  = rsp_offset_ff;
   assign rsp_ch.flash_data    = rsp_fdata_ff;

endmodule

// ----- sv/blfc_checker.sv -----
// ----------------------------------------------------------------------------
// blfc_checker
// Port-level checks of the bank latch block, bound to its top level.
// ----------------------------------------------------------------------------
module blfc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [blfc_pkg::FOP_W-1:0]    flash_op,
   input logic [blfc_pkg::PRG_W-1:0]    flash_bank,
   input logic [blfc_pkg::OFFSET_W-1:0] flash_offset,
   input logic [blfc_pkg::DATA_W-1:0]   flash_data
);
   import blfc_pkg::*;

   // The remainder unit is busy after an item is taken, so no second item follows.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while the previous one is still in work");

   a_no_op_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && flash_op == FOP_NONE |->
         flash_bank == '0 && flash_offset == '0 && flash_data == '0)
      else $error("flash fields not cleared on an item without flash operation");

   a_erase_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && flash_op == FOP_ERASE |->
         flash_offset[11:0] == '0 && flash_data == DAT_ERASED)
      else $error("erase item without sector-aligned offset or erased data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(flash_op) && $stable(flash_offset))
      else $error("stalled result item changed");

endmodule

bind bank_latch_with_flash_commands blfc_checker u_blfc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .flash_op     (rsp_ch.flash_op),
   .flash_bank   (rsp_ch.flash_bank),
   .flash_offset (rsp_ch.flash_offset),
   .flash_data   (rsp_ch.flash_data)
);

// ----- tb/bank_latch_with_flash_commands_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_latch_with_flash_commands_tb
// Self-checking bench for the bank latch and its flash command decoder.
// ----------------------------------------------------------------------------
// A short table of CPU writes runs first: a few rows after reset carry their
// mapping typed in, and the rest walk the ID, program, erase and soft reset
// command sequences. Random phases follow, each under its own register
// setting. They mix plain latch writes, well-formed flash command sequences
// with random content, broken sequences and noise. Every result item is
// compared field by field with its typed-in mapping or a mapping predictor
// that keeps its own copy of the latch, the decoder state and the registers.
// ----------------------------------------------------------------------------
module bank_latch_with_flash_commands_tb;
   import blfc_pkg::*;

   localparam int BANK_LIMIT    = DEF_MAX_PRG_BANKS;
   localparam int PHASES        = 16;
   localparam int PHASE_ITEMS   = 89;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_AFTER    = 400;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 800000;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] rom_value;
   } cpu_write_type;

   typedef struct packed {
      logic                latch_written;
      logic [PRG_W-1:0]    prg_bank;
      logic [CHR_W-1:0]    chr_bank;
      mir_type             mirroring;
      logic                id_mode;
      fop_type             flash_op;
      logic [PRG_W-1:0]    flash_bank;
      logic [OFFSET_W-1:0] flash_offset;
      logic [DATA_W-1:0]   flash_data;
   } map_result_type;

   typedef struct packed {
      logic           flash;
      cpu_write_type  w;
      logic           typed;
      map_result_type want;
   } directed_row_type;

   localparam map_result_type NO_MAP = '0;

   // The first rows run under the reset setting, so their mapping is typed in.
   localparam directed_row_type DIRECTED_ROWS [30] = '{
      '{1'b0, '{16'h8000, 8'hFF, 8'hFF}, 1'b1,
        '{1'b1, 5'd31, 2'd3, MIR_HORZ, 1'b0, FOP_NONE, 5'd0, 14'd0, 8'd0}},
      '{1'b0, '{16'hFFFF, 8'hFF, 8'h00}, 1'b1,
        '{1'b1, 5'd0, 2'd0, MIR_HORZ, 1'b0, FOP_NONE, 5'd0, 14'd0, 8'd0}},
      '{1'b0, '{16'h0000, 8'h80, 8'h80}, 1'b1,
        '{1'b1, 5'd0, 2'd0, MIR_HORZ, 1'b0, FOP_NONE, 5'd0, 14'd0, 8'd0}},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_AA, 8'hFF}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ZERO, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_B, DAT_55, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_ID, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_AA, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ZERO, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_B, DAT_55, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_PROGRAM, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{16'hFFFF, 8'h9F, 8'hFF}, 1'b0, NO_MAP},
      '{1'b1, '{16'hBFFF, 8'h5A, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_AA, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ZERO, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_B, DAT_55, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_ERASE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ONE, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_A, DAT_AA, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_HI_BASE, DAT_ZERO, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{ADDR_UNLOCK_B, DAT_55, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{16'hE000, 8'h00, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{16'hB7FF, DAT_CONFIRM, 8'h00}, 1'b0, NO_MAP},
      '{1'b1, '{16'h8000, DAT_RESET, 8'h00}, 1'b0, NO_MAP}
   };

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   blfc_req_if req_ch ();
   blfc_rsp_if rsp_ch ();

   bank_latch_with_flash_commands dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Register copies and mapping state of the predictor.
   logic                  cfg_flashable;
   logic [SUBMAP_W-1:0]   cfg_submapper;
   logic [NTMODE_W-1:0]   cfg_nt_mode;
   logic [COUNT_W-1:0]    cfg_bank_count;
   logic [CHR_W-1:0]      cfg_chr_mask;
   logic [DATA_W-1:0]     latch_copy;
   flash_state_type       decoder_state;
   logic                  id_active;
   logic [PRG_W-1:0]      target_bank;

   map_result_type expected_maps [$];
   cpu_write_type  burst_q [$];

   int unsigned mismatch_count   = 0;
   int unsigned items_sent       = 0;
   int unsigned results_seen     = 0;
   int unsigned settings_applied = 0;
   int unsigned programs_seen    = 0;
   int unsigned erases_seen      = 0;
   int unsigned cycle_count      = 0;
   int unsigned stall_left       = 0;
   bit          hold_done        = 1'b0;
   bit          steady_flow      = 1'b0;

   function automatic logic [PRG_W-1:0] reduce_bank(logic [DATA_W-1:0] b);
      int unsigned n;
      n = int'(cfg_bank_count);
      if (n == 0) n = 1;
      if (n > BANK_LIMIT) n = BANK_LIMIT;
      return PRG_W'(32'(b[4:0]) % n);
   endfunction

   function automatic map_result_type predict_write(cpu_write_type w);
      map_result_type    r;
      logic [DATA_W-1:0] d;
      logic              upper;
      flash_state_type   follow;
      r = NO_MAP;
      d = w.data;
      upper = (w.addr >= ADDR_HI_BASE);
      if (!cfg_flashable) begin
         if (!((cfg_submapper == SUBMAP_HI_ONLY || cfg_submapper == SUBMAP_HV_D7 ||
                cfg_submapper == SUBMAP_HI_ONLY_B) && !upper)) begin
            if (cfg_submapper == SUBMAP_CONFLICT || cfg_submapper == SUBMAP_CONFLICT_B)
               d = d & w.rom_value;
            latch_copy = d;
            r.latch_written = 1'b1;
         end
      end else begin
         if (upper) begin
            latch_copy = d;
            r.latch_written = 1'b1;
         end
         if (w.data == DAT_RESET) begin
            decoder_state = FL_IDLE;
            id_active = 1'b0;
         end else begin
            follow = FL_IDLE;
            case (decoder_state)
               FL_IDLE: if (w.addr == ADDR_HI_BASE && w.data == DAT_ONE) follow = FL_C1;
               FL_C1: if (w.addr == ADDR_UNLOCK_A && w.data == DAT_AA) follow = FL_AA;
               FL_AA: if (w.addr == ADDR_HI_BASE && w.data == DAT_ZERO) follow = FL_C0;
               FL_C0: if (w.addr == ADDR_UNLOCK_B && w.data == DAT_55) follow = FL_55;
               FL_55: if (w.addr == ADDR_HI_BASE && w.data == DAT_ONE) follow = FL_C1B;
               FL_C1B: begin
                  if (w.addr == ADDR_UNLOCK_A) begin
                     if (w.data == DAT_ID) id_active = 1'b1;
                     else if (w.data == DAT_PROGRAM) follow = FL_WR_BANK;
                     else if (w.data == DAT_ERASE) follow = FL_ER_C1;
                  end
               end
               FL_WR_BANK: begin
                  if (upper) begin
                     target_bank = w.data[PRG_W-1:0];
                     follow = FL_WR_DATA;
                  end
               end
               FL_WR_DATA: begin
                  if (!upper) begin
                     r.flash_op = FOP_PROGRAM;
                     r.flash_offset = w.addr[OFFSET_W-1:0];
                     r.flash_data = w.data;
                  end
               end
               FL_ER_C1: if (w.addr == ADDR_HI_BASE && w.data == DAT_ONE) follow = FL_ER_AA;
               FL_ER_AA: if (w.addr == ADDR_UNLOCK_A && w.data == DAT_AA) follow = FL_ER_C0;
               FL_ER_C0: if (w.addr == ADDR_HI_BASE && w.data == DAT_ZERO) follow = FL_ER_55;
               FL_ER_55: if (w.addr == ADDR_UNLOCK_B && w.data == DAT_55) follow = FL_ER_BANK;
               FL_ER_BANK: begin
                  if (upper) begin
                     target_bank = w.data[PRG_W-1:0];
                     follow = FL_ER_DATA;
                  end
               end
               FL_ER_DATA: begin
                  if (!upper && w.data == DAT_CONFIRM) begin
                     r.flash_op = FOP_ERASE;
                     r.flash_offset = w.addr[OFFSET_W-1:0] & ERASE_MASK[OFFSET_W-1:0];
                     r.flash_data = DAT_ERASED;
                  end
               end
               default: ;
            endcase
            decoder_state = follow;
         end
      end
      r.prg_bank = reduce_bank(latch_copy);
      r.chr_bank = latch_copy[6:5] & cfg_chr_mask;
      if (cfg_submapper == SUBMAP_HV_D7) begin
         r.mirroring = latch_copy[7] ? MIR_VERT : MIR_HORZ;
      end else begin
         case (cfg_nt_mode)
            NT_HORZ: r.mirroring = MIR_HORZ;
            NT_VERT: r.mirroring = MIR_VERT;
            NT_SINGLE: r.mirroring = latch_copy[7] ? MIR_SCREEN_A : MIR_SCREEN_B;
            default: r.mirroring = MIR_FOUR;
         endcase
      end
      r.id_mode = id_active;
      if (r.flash_op != FOP_NONE) r.flash_bank = reduce_bank({3'b000, target_bank});
      return r;
   endfunction

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic logic [DATA_W-1:0] any_but_reset();
      logic [DATA_W-1:0] d;
      do d = DATA_W'($urandom); while (d == DAT_RESET);
      return d;
   endfunction

   function automatic cpu_write_type noise_write();
      cpu_write_type     w;
      logic [DATA_W-1:0] codes [10];
      codes = '{DAT_ONE, DAT_ZERO, DAT_AA, DAT_55, DAT_ID, DAT_PROGRAM, DAT_ERASE,
                DAT_CONFIRM, DAT_RESET, DAT_ERASED};
      case ($urandom_range(0, 5))
         0: w.addr = ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
         1: w.addr = ADDR_W'($urandom_range(16'h8000, 16'hBFFF));
         2: w.addr = ADDR_W'($urandom);
         3: w.addr = ADDR_HI_BASE;
         4: w.addr = ADDR_UNLOCK_A;
         default: w.addr = ADDR_UNLOCK_B;
      endcase
      w.data = $urandom_range(0, 1) ? DATA_W'($urandom) : codes[$urandom_range(0, 9)];
      w.rom_value = DATA_W'($urandom);
      return w;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic queue_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      burst_q.push_back('{a, d, DATA_W'($urandom)});
   endtask

   // The unlock prefix; the erase sequence repeats its first four writes.
   task automatic queue_unlock(int n);
      for (int i = 0; i < n; i++) begin
         case (i)
            0, 4: queue_write(ADDR_HI_BASE, DAT_ONE);
            1: queue_write(ADDR_UNLOCK_A, DAT_AA);
            2: queue_write(ADDR_HI_BASE, DAT_ZERO);
            default: queue_write(ADDR_UNLOCK_B, DAT_55);
         endcase
      end
   endtask

   task automatic offer_write(cpu_write_type w, logic typed, map_result_type typed_map);
      map_result_type predicted;
      req_ch.valid <= 1'b1;
      req_ch.addr <= w.addr;
      req_ch.data <= w.data;
      req_ch.rom_value <= w.rom_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_write(w);
      if (predicted.flash_op == FOP_PROGRAM) programs_seen++;
      else if (predicted.flash_op == FOP_ERASE) erases_seen++;
      expected_maps.push_back(typed ? typed_map : predicted);
      items_sent++;
      if (!steady_flow && $urandom_range(0, 99) < 35) begin
         req_ch.valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   // Waits until every result has come back and the block has gone quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back transfers keep psel high; the caller drops it afterwards.
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic apply_setting(logic flash, logic [SUBMAP_W-1:0] sub,
                                logic [NTMODE_W-1:0] nt, logic [COUNT_W-1:0] count,
                                logic [CHR_W-1:0] mask);
      settle();
      csr_write(REG_FLASHABLE, CSR_DATA_W'(flash));
      csr_write(REG_SUBMAPPER, CSR_DATA_W'(sub));
      csr_write(REG_NT_MODE, CSR_DATA_W'(nt));
      csr_write(REG_BANK_COUNT, CSR_DATA_W'(count));
      csr_write(REG_CHR_MASK, CSR_DATA_W'(mask));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cfg_flashable = flash;
      cfg_submapper = sub;
      cfg_nt_mode = nt;
      cfg_bank_count = count;
      cfg_chr_mask = mask;
      settings_applied++;
   endtask

   // Result side: random stalls, plus one long hold-off while writes are offered.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER && req_ch.valid) begin
         hold_done <= 1'b1;
         stall_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
         stall_left <= idle_length() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      map_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_maps.size() == 0) begin
            $display("%0t: result item with no write waiting for it", $time);
            mismatch_count++;
         end else begin
            want = expected_maps.pop_front();
            check_field("latch_written", 32'(want.latch_written), 32'(rsp_ch.latch_written));
            check_field("prg_bank", 32'(want.prg_bank), 32'(rsp_ch.prg_bank));
            check_field("chr_bank", 32'(want.chr_bank), 32'(rsp_ch.chr_bank));
            check_field("mirroring", 32'(want.mirroring), 32'(rsp_ch.mirroring));
            check_field("id_mode", 32'(want.id_mode), 32'(rsp_ch.id_mode));
            check_field("flash_op", 32'(want.flash_op), 32'(rsp_ch.flash_op));
            check_field("flash_bank", 32'(want.flash_bank), 32'(rsp_ch.flash_bank));
            check_field("flash_offset", 32'(want.flash_offset), 32'(rsp_ch.flash_offset));
            check_field("flash_data", 32'(want.flash_data), 32'(rsp_ch.flash_data));
         end
         results_seen <= results_seen + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_maps.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      directed_row_type   row;
      cpu_write_type      w;
      int unsigned        start;
      int unsigned        kind;
      int unsigned        cut;
      logic [COUNT_W-1:0] count;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.addr = '0;
      req_ch.data = '0;
      req_ch.rom_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_flashable = 1'b0;
      cfg_submapper = SUBMAP_CONFLICT;
      cfg_nt_mode = NT_HORZ;
      cfg_bank_count = BANK_COUNT_RESET;
      cfg_chr_mask = CHR_MASK_RESET;
      latch_copy = '0;
      decoder_state = FL_IDLE;
      id_active = 1'b0;
      target_bank = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         // The flash rows run with D7 mirroring and a bank count that wraps.
         if (row.flash && !cfg_flashable)
            apply_setting(1'b1, SUBMAP_HV_D7, NT_FOUR, COUNT_W'(20), CHR_W'(1));
         offer_write(row.w, row.typed, row.want);
      end

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: count = '0;
            1: count = COUNT_W'(1);
            2: count = '1;
            3: count = COUNT_W'(BANK_LIMIT);
            4: count = COUNT_W'(2);
            default: count = COUNT_W'($urandom_range(1, BANK_LIMIT));
         endcase
         apply_setting(phase % 2 == 1, SUBMAP_W'((phase / 2) % 8), NTMODE_W'((phase / 2) % 4),
                       count, CHR_W'(phase % 4));
         steady_flow <= (phase % 5 == 3);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if (!cfg_flashable) begin
               case ($urandom_range(0, 4))
                  0, 1: w.addr = ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
                  2, 3: w.addr = ADDR_W'($urandom_range(16'h8000, 16'hBFFF));
                  default: w.addr = ADDR_W'($urandom_range(0, 16'h7FFF));
               endcase
               w.data = DATA_W'($urandom);
               w.rom_value = ($urandom_range(0, 9) < 3) ? DAT_ERASED : DATA_W'($urandom);
               offer_write(w, 1'b0, NO_MAP);
            end else begin
               kind = $urandom_range(0, 99);
               burst_q.delete();
               if (kind < 75) begin
                  queue_unlock(5);
                  case (kind % 3)
                     0: queue_write(ADDR_UNLOCK_A, DAT_ID);
                     1: begin
                        queue_write(ADDR_UNLOCK_A, DAT_PROGRAM);
                        queue_write(ADDR_W'($urandom_range(16'hC000, 16'hFFFF)), any_but_reset());
                        queue_write(ADDR_W'($urandom_range(0, 16'hBFFF)), any_but_reset());
                     end
                     default: begin
                        queue_write(ADDR_UNLOCK_A, DAT_ERASE);
                        queue_unlock(4);
                        queue_write(ADDR_W'($urandom_range(16'hC000, 16'hFFFF)), any_but_reset());
                        queue_write(ADDR_W'($urandom_range(0, 16'hBFFF)), DAT_CONFIRM);
                     end
                  endcase
                  // A share of the sequences is broken: one write swapped, maybe cut short.
                  if (kind >= 60) begin
                     burst_q[$urandom_range(0, burst_q.size() - 1)] = noise_write();
                     if ($urandom_range(0, 1) == 1) begin
                        cut = $urandom_range(1, burst_q.size());
                        while (burst_q.size() > cut) void'(burst_q.pop_back());
                     end
                  end
               end else if (kind < 83) begin
                  queue_write(ADDR_W'($urandom), DAT_RESET);
               end else begin
                  repeat ($urandom_range(1, 3)) burst_q.push_back(noise_write());
               end
               foreach (burst_q[j]) offer_write(burst_q[j], 1'b0, NO_MAP);
            end
         end
      end

      settle();
      $display("Covered %0d CPU writes under %0d register settings, %0d results compared.",
               items_sent, settings_applied, results_seen);
      $display("The decoder completed %0d byte programs and %0d sector erases.",
               programs_seen, erases_seen);
      if (mismatch_count == 0 && expected_maps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
